FILE: hdl/pscll_pkg.sv
// Types, constants and the load cost table shared by the credit load limiter files.
`default_nettype none
package pscll_pkg;

    localparam int BAL_W   = 24;
    localparam int SEC_W   = 32;
    localparam int RATE_W  = 10;
    localparam int LIMIT_W = 20;
    localparam int DEBIT_W = 21;
    localparam int AMT_W   = 16;
    localparam int COST_W  = 8;
    localparam int PROD_W  = RATE_W + SEC_W - 1;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_INIT   = 3'd1;
    localparam logic [2:0] ACT_CHARGE = 3'd2;
    localparam logic [2:0] ACT_ADJUST = 3'd3;
    localparam logic [2:0] ACT_WARN   = 3'd4;
    localparam logic [2:0] ACT_CUTOFF = 3'd5;

    localparam logic [1:0] REG_RATE   = 2'd0;
    localparam logic [1:0] REG_LIMIT  = 2'd1;
    localparam logic [1:0] REG_WARN   = 2'd2;
    localparam logic [1:0] REG_CUTOFF = 2'd3;

    localparam logic [RATE_W-1:0]         RATE_RST   = 10'd100;
    localparam logic [LIMIT_W-1:0]        LIMIT_RST  = 20'd500;
    localparam logic signed [DEBIT_W-1:0] WARN_RST   = -21'sd500;
    localparam logic signed [DEBIT_W-1:0] CUTOFF_RST = -21'sd1000;

    localparam logic signed [BAL_W-1:0] BAL_MIN = 24'sh800000;

    typedef struct packed {
        logic [2:0]              action;
        logic [5:0]              source_id;
        logic [3:0]              load_type;
        logic signed [AMT_W-1:0] credit_amount;
        logic                    privileged;
    } t_req;

    typedef struct packed {
        logic                    needs_action;
        logic                    first_report;
        logic signed [BAL_W-1:0] balance_now;
    } t_rsp;

    typedef struct packed {
        logic signed [BAL_W-1:0] balance;
        logic [SEC_W-1:0]        last_refill;
        logic [SEC_W-1:0]        last_warn;
        logic                    cut_rep;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_REF  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    function automatic logic signed [COST_W-1:0] cost_of(input logic [3:0] lt);
        logic signed [COST_W-1:0] c;
        unique case (lt)
            4'd0:    c = -8'sd10;
            4'd1:    c = -8'sd1;
            4'd2:    c = -8'sd100;
            4'd3:    c = -8'sd5;
            4'd4:    c = -8'sd20;
            4'd5:    c = -8'sd10;
            4'd6:    c = -8'sd10;
            4'd7:    c = -8'sd20;
            4'd8:    c = -8'sd50;
            4'd9:    c = -8'sd10;
            4'd10:   c = -8'sd2;
            4'd11:   c = -8'sd10;
            4'd12:   c = -8'sd5;
            4'd13:   c = -8'sd1;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/pscll_if.sv
// Valid/ready channel interfaces for limiter requests and results.
`default_nettype none
interface pscll_req_if;
    logic            valid;
    logic            ready;
    pscll_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pscll_rsp_if;
    logic            valid;
    logic            ready;
    pscll_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/per_source_credit_load_limiter_top.sv
// Top level of the per-source credit load limiter: source table, refill and charge logic.
// Each request passes in order from transfer to result through these steps: the transfer, which
// issues the read of the source table, then the multiply of rate by elapsed seconds, the
// refill, and the charge/check with write-back, after which the next request is taken. The
// source table is a single-port-read synchronous memory; since one request is in flight at a
// time, no forwarding is required. The result register lets a new request enter while the
// previous result still waits; the final step holds while that register is full. A source must
// be initialized before any other access to it. Configuration registers sit at byte addresses
// 0, 4, 8 and 12 (rate, limit, warn, cutoff) and should be written only while idle.
`default_nettype none
module per_source_credit_load_limiter_top #(
    parameter int NUM_SOURCES = 64
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    pscll_req_if.sink                      i_req,
    pscll_rsp_if.source                    o_rsp,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [pscll_pkg::APB_AW-1:0]    paddr,
    input  wire [pscll_pkg::APB_DW-1:0]    pwdata,
    output logic [pscll_pkg::APB_DW-1:0]   prdata,
    output logic                           pready
);
    localparam int AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SW = (AW > 6) ? AW : 6;
    localparam int BW = pscll_pkg::BAL_W;
    localparam int SEC_W = pscll_pkg::SEC_W;
    localparam int PW = pscll_pkg::PROD_W;
    localparam int RW = PW + 2;

    // configuration
    logic [pscll_pkg::RATE_W-1:0]         r_rate;
    logic [pscll_pkg::LIMIT_W-1:0]        r_limit;
    logic signed [pscll_pkg::DEBIT_W-1:0] r_warn;
    logic signed [pscll_pkg::DEBIT_W-1:0] r_cutoff;
    logic                                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= pscll_pkg::RATE_RST;
            r_limit  <= pscll_pkg::LIMIT_RST;
            r_warn   <= pscll_pkg::WARN_RST;
            r_cutoff <= pscll_pkg::CUTOFF_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                pscll_pkg::REG_RATE:   r_rate   <= pwdata[pscll_pkg::RATE_W-1:0];
                pscll_pkg::REG_LIMIT:  r_limit  <= pwdata[pscll_pkg::LIMIT_W-1:0];
                pscll_pkg::REG_WARN:   r_warn   <= $signed(pwdata[pscll_pkg::DEBIT_W-1:0]);
                pscll_pkg::REG_CUTOFF: r_cutoff <= $signed(pwdata[pscll_pkg::DEBIT_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            pscll_pkg::REG_RATE:   prdata = {22'd0, r_rate};
            pscll_pkg::REG_LIMIT:  prdata = {12'd0, r_limit};
            pscll_pkg::REG_WARN:   prdata = {{11{r_warn[20]}}, r_warn};
            pscll_pkg::REG_CUTOFF: prdata = {{11{r_cutoff[20]}}, r_cutoff};
            default:               prdata = '0;
        endcase
    end

    // control
    pscll_pkg::t_state   r_state;
    pscll_pkg::t_state   n_state;
    pscll_pkg::t_req     r_req;
    logic [AW-1:0]       r_addr;
    logic                r_act_ok;
    logic [SEC_W-1:0]    r_sec;
    logic                r_ovalid;
    pscll_pkg::t_rsp     r_rsp;
    logic                acc;
    logic                fin_go;
    logic                mem_we;
    logic [SW-1:0]       sid_ext;
    logic                in_rng;
    logic                act_ok;

    assign i_req.ready = (r_state == pscll_pkg::ST_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign sid_ext     = SW'(i_req.data.source_id);
    assign in_rng      = int'(i_req.data.source_id) < NUM_SOURCES;
    assign act_ok      = in_rng && (i_req.data.action != pscll_pkg::ACT_TICK) &&
                         (i_req.data.action <= pscll_pkg::ACT_CUTOFF);
    assign fin_go      = (r_state == pscll_pkg::ST_FIN) && (!r_ovalid || o_rsp.ready);
    assign mem_we      = fin_go && r_act_ok;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pscll_pkg::ST_IDLE: if (acc) n_state = pscll_pkg::ST_RD;
            pscll_pkg::ST_RD:   n_state = pscll_pkg::ST_REF;
            pscll_pkg::ST_REF:  n_state = pscll_pkg::ST_FIN;
            pscll_pkg::ST_FIN:  if (fin_go) n_state = pscll_pkg::ST_IDLE;
            default:            n_state = pscll_pkg::ST_IDLE;
        endcase
    end

    // source table
    pscll_pkg::t_entry r_mem [NUM_SOURCES];
    pscll_pkg::t_entry r_rd_ent;
    pscll_pkg::t_entry n_ent;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_ent <= r_mem[sid_ext[AW-1:0]];
        end
        if (mem_we) begin
            r_mem[r_addr] <= n_ent;
        end
    end

    // elapsed time and refill product
    logic [SEC_W-1:0] dsec;
    logic             r_dnz;
    logic             r_dok;
    logic [PW-1:0]    r_prod;

    assign dsec = r_sec - r_rd_ent.last_refill;

    // refill
    logic signed [RW-1:0] ref_sum;
    logic                 ref_over;
    logic signed [BW-1:0] r_bal1;
    logic                 r_cut1;
    logic [SEC_W-1:0]     r_lrs;

    assign ref_sum  = $signed({{(RW-BW){r_rd_ent.balance[BW-1]}}, r_rd_ent.balance}) +
                      $signed({2'b00, r_prod});
    assign ref_over = ref_sum > $signed({{(RW-pscll_pkg::LIMIT_W){1'b0}}, r_limit});

    // charge and checks
    logic signed [16:0]   credit;
    logic signed [25:0]   chg_sum;
    logic signed [BW-1:0] bal2;
    logic signed [24:0]   bal1_x;
    logic signed [24:0]   bal2_x;
    logic signed [24:0]   warn_x;
    logic signed [24:0]   cut_x;
    logic                 same_sec;
    pscll_pkg::t_rsp      n_rsp;

    always_comb begin
        if (r_req.action == pscll_pkg::ACT_CHARGE) begin
            credit = 17'(pscll_pkg::cost_of(r_req.load_type));
        end else begin
            credit = 17'(r_req.credit_amount);
        end
    end

    assign chg_sum = 26'(r_bal1) + 26'(credit);
    always_comb begin
        priority if (chg_sum > $signed({6'd0, r_limit})) begin
            bal2 = {4'd0, r_limit};
        end else if (chg_sum < 26'(pscll_pkg::BAL_MIN)) begin
            bal2 = pscll_pkg::BAL_MIN;
        end else begin
            bal2 = chg_sum[BW-1:0];
        end
    end

    assign bal1_x   = 25'(r_bal1);
    assign bal2_x   = 25'(bal2);
    assign warn_x   = 25'(r_warn);
    assign cut_x    = 25'(r_cutoff);
    assign same_sec = (r_rd_ent.last_warn == r_sec);

    always_comb begin
        n_ent             = r_rd_ent;
        n_ent.balance     = r_bal1;
        n_ent.last_refill = r_lrs;
        n_ent.cut_rep     = r_cut1;
        n_rsp             = '0;
        unique case (r_req.action)
            pscll_pkg::ACT_INIT: begin
                n_ent.balance     = '0;
                n_ent.last_refill = r_sec;
                n_ent.last_warn   = '0;
                n_ent.cut_rep     = 1'b0;
            end
            pscll_pkg::ACT_CHARGE, pscll_pkg::ACT_ADJUST: begin
                n_ent.balance      = bal2;
                n_rsp.balance_now  = bal2;
                n_rsp.needs_action = !r_req.privileged && (bal2_x < warn_x) &&
                                     !((bal2_x >= cut_x) && same_sec);
            end
            pscll_pkg::ACT_WARN: begin
                n_rsp.balance_now = r_bal1;
                if (!r_req.privileged && (bal1_x <= warn_x) && !same_sec) begin
                    n_ent.last_warn    = r_sec;
                    n_rsp.needs_action = 1'b1;
                end
            end
            pscll_pkg::ACT_CUTOFF: begin
                n_rsp.balance_now = r_bal1;
                if (!r_req.privileged && (bal1_x <= cut_x)) begin
                    n_rsp.first_report = !r_cut1;
                    n_rsp.needs_action = 1'b1;
                    n_ent.cut_rep      = 1'b1;
                end
            end
            default: ;
        endcase
        if (!r_act_ok) begin
            n_rsp = '0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req    <= i_req.data;
            r_addr   <= sid_ext[AW-1:0];
            r_act_ok <= act_ok;
        end
        if (r_state == pscll_pkg::ST_RD) begin
            r_dnz  <= (dsec != '0);
            r_dok  <= (dsec != '0) && !dsec[SEC_W-1];
            r_prod <= PW'(r_rate) * PW'(dsec[SEC_W-2:0]);
        end
        if (r_state == pscll_pkg::ST_REF) begin
            if (r_dok && ref_over) begin
                r_bal1 <= {4'd0, r_limit};
                r_cut1 <= 1'b0;
            end else if (r_dok) begin
                r_bal1 <= ref_sum[BW-1:0];
                r_cut1 <= r_rd_ent.cut_rep;
            end else begin
                r_bal1 <= r_rd_ent.balance;
                r_cut1 <= r_rd_ent.cut_rep;
            end
            r_lrs <= r_dnz ? r_sec : r_rd_ent.last_refill;
        end
        if (fin_go) begin
            r_rsp <= n_rsp;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pscll_pkg::ST_IDLE;
            r_sec    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_go && (r_req.action == pscll_pkg::ACT_TICK)) begin
                r_sec <= r_sec + 1'b1;
            end
            if (fin_go) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/pscll_chk.sv
// Port-level checker for the credit load limiter, bound to the top level.
`default_nettype none
module pscll_chk (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       in_valid,
    input wire                       in_ready,
    input wire                       out_valid,
    input wire                       out_ready,
    input wire                       needs_action,
    input wire                       first_report,
    input wire [pscll_pkg::BAL_W-1:0] balance_now,
    input wire                       pready
);
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one in flight");

    a_first_needs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> needs_action || !first_report)
        else $error("first report without action");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(balance_now) &&
        $stable(needs_action) && $stable(first_report))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind per_source_credit_load_limiter_top pscll_chk u_pscll_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_valid     (i_req.valid),
    .in_ready     (i_req.ready),
    .out_valid    (o_rsp.valid),
    .out_ready    (o_rsp.ready),
    .needs_action (o_rsp.data.needs_action),
    .first_report (o_rsp.data.first_report),
    .balance_now  (o_rsp.data.balance_now),
    .pready       (pready)
);
`default_nettype wire

FILE: tb/tb_per_source_credit_load_limiter_top.sv
// Testbench for the credit load limiter: directed table, random traffic and a result predictor.
`timescale 1ns / 1ps
module tb_per_source_credit_load_limiter_top;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [pscll_pkg::APB_AW-1:0] paddr;
    logic [pscll_pkg::APB_DW-1:0] pwdata;
    wire  [pscll_pkg::APB_DW-1:0] prdata;
    wire                          pready;

    pscll_req_if req_if ();
    pscll_rsp_if rsp_if ();

    per_source_credit_load_limiter_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    typedef struct {
        pscll_pkg::t_req req;
        bit              typed;
        pscll_pkg::t_rsp want;
    } t_dir_row;

    // predictor state
    logic [pscll_pkg::SEC_W-1:0]           now_sec = '0;
    logic signed [pscll_pkg::BAL_W-1:0]    bal_tbl [64];
    logic [pscll_pkg::SEC_W-1:0]           refill_sec [64];
    logic [pscll_pkg::SEC_W-1:0]           warn_sec [64];
    bit                                    cut_flag [64];
    logic [pscll_pkg::RATE_W-1:0]          cfg_rate = 10'd100;
    logic [pscll_pkg::LIMIT_W-1:0]         cfg_limit = 20'd500;
    logic signed [pscll_pkg::DEBIT_W-1:0]  cfg_warn = -21'sd500;
    logic signed [pscll_pkg::DEBIT_W-1:0]  cfg_cutoff = -21'sd1000;
    int load_cost [16] = '{-10, -1, -100, -5, -20, -10, -10, -20, -50, -10, -2, -10, -5, -1,
                           0, 0};

    pscll_pkg::t_rsp verdict_q [$];
    t_dir_row        dir_rows [$];
    bit              live_map [64];
    int              live_ids [$];
    int              mismatches = 0;
    int              results_seen = 0;
    bit              idle_on = 1'b1;

    function automatic logic signed [pscll_pkg::BAL_W-1:0] clamp_bal(input longint b);
        if (b > 64'sd8388607) return 24'sh7FFFFF;
        if (b < -64'sd8388608) return 24'sh800000;
        return b[pscll_pkg::BAL_W-1:0];
    endfunction

    function automatic void refill_entry(input int s);
        logic [pscll_pkg::SEC_W-1:0] d;
        longint b;
        d = now_sec - refill_sec[s];
        if (d != '0) begin
            if (!d[pscll_pkg::SEC_W-1]) begin
                b = longint'(bal_tbl[s]) + longint'(cfg_rate) * longint'(d);
                if (b > longint'(cfg_limit)) begin
                    b = longint'(cfg_limit);
                    cut_flag[s] = 1'b0;
                end
                bal_tbl[s] = clamp_bal(b);
            end
            refill_sec[s] = now_sec;
        end
    endfunction

    function automatic bit apply_credit(input int s, input longint amt, input bit priv);
        longint b;
        refill_entry(s);
        b = longint'(bal_tbl[s]) + amt;
        if (b > longint'(cfg_limit)) b = longint'(cfg_limit);
        bal_tbl[s] = clamp_bal(b);
        if (priv) return 1'b0;
        if (bal_tbl[s] >= cfg_warn) return 1'b0;
        if (bal_tbl[s] >= cfg_cutoff && warn_sec[s] == now_sec) return 1'b0;
        return 1'b1;
    endfunction

    function automatic pscll_pkg::t_rsp predict_verdict(input pscll_pkg::t_req r);
        pscll_pkg::t_rsp v;
        int              s;
        v = '0;
        s = int'(r.source_id);
        if (r.action == pscll_pkg::ACT_TICK) begin
            now_sec = now_sec + 1'b1;
            return v;
        end
        if (r.action > pscll_pkg::ACT_CUTOFF) return v;
        case (r.action)
            pscll_pkg::ACT_INIT: begin
                bal_tbl[s] = '0;
                refill_sec[s] = now_sec;
                warn_sec[s] = '0;
                cut_flag[s] = 1'b0;
            end
            pscll_pkg::ACT_CHARGE: begin
                v.needs_action = apply_credit(s, longint'(load_cost[r.load_type]),
                                              r.privileged);
            end
            pscll_pkg::ACT_ADJUST: begin
                v.needs_action = apply_credit(s, longint'(r.credit_amount), r.privileged);
            end
            pscll_pkg::ACT_WARN: begin
                refill_entry(s);
                if (!r.privileged && bal_tbl[s] <= cfg_warn && warn_sec[s] != now_sec) begin
                    warn_sec[s] = now_sec;
                    v.needs_action = 1'b1;
                end
            end
            default: begin
                refill_entry(s);
                if (!r.privileged && bal_tbl[s] <= cfg_cutoff) begin
                    v.first_report = !cut_flag[s];
                    cut_flag[s] = 1'b1;
                    v.needs_action = 1'b1;
                end
            end
        endcase
        v.balance_now = bal_tbl[s];
        return v;
    endfunction

    function automatic pscll_pkg::t_req make_req(input logic [2:0] act, input int sid,
                                                 input int lt, input int amt, input bit priv);
        pscll_pkg::t_req r;
        r.action = act;
        r.source_id = sid[5:0];
        r.load_type = lt[3:0];
        r.credit_amount = amt[15:0];
        r.privileged = priv;
        return r;
    endfunction

    function automatic pscll_pkg::t_rsp verdict(input bit n, input bit f, input int bal);
        pscll_pkg::t_rsp v;
        v.needs_action = n;
        v.first_report = f;
        v.balance_now = bal[pscll_pkg::BAL_W-1:0];
        return v;
    endfunction

    function automatic void mark_live(input int s);
        if (!live_map[s]) begin
            live_map[s] = 1'b1;
            live_ids.push_back(s);
        end
    endfunction

    function automatic int pick_gap();
        int p;
        if (!idle_on) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic add_row(input logic [2:0] act, input int sid, input int lt, input int amt,
                           input bit priv, input bit typed, input bit n, input bit f,
                           input int bal);
        t_dir_row row;
        row.req = make_req(act, sid, lt, amt, priv);
        row.typed = typed;
        row.want = verdict(n, f, bal);
        dir_rows.push_back(row);
    endtask

    task automatic push_req(input pscll_pkg::t_req r, input bit typed,
                            input pscll_pkg::t_rsp want);
        int              gap;
        pscll_pkg::t_rsp pred;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.data <= r;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pred = predict_verdict(r);
        verdict_q.push_back(typed ? want : pred);
    endtask

    function automatic pscll_pkg::t_req gen_item();
        int p, sid, lt, amt, q;
        bit priv;
        logic [2:0] act;
        p = $urandom_range(0, 99);
        lt = $urandom_range(0, 15);
        priv = ($urandom_range(0, 4) == 0);
        q = $urandom_range(0, 9);
        if (q == 0) amt = -32768;
        else if (q == 1) amt = 32767;
        else if (q < 6) amt = int'($urandom_range(0, 400)) - 300;
        else amt = int'($urandom_range(0, 65535));
        sid = $urandom_range(0, 63);
        if (p < 10) act = pscll_pkg::ACT_TICK;
        else if (p < 18 || live_ids.size() == 0) act = pscll_pkg::ACT_INIT;
        else if (p < 40) act = pscll_pkg::ACT_CHARGE;
        else if (p < 65) act = pscll_pkg::ACT_ADJUST;
        else if (p < 78) act = pscll_pkg::ACT_WARN;
        else if (p < 92) act = pscll_pkg::ACT_CUTOFF;
        else act = 3'($urandom_range(6, 7));
        if (act == pscll_pkg::ACT_INIT) mark_live(sid);
        else if (act != pscll_pkg::ACT_TICK && act <= pscll_pkg::ACT_CUTOFF)
            sid = live_ids[$urandom_range(0, live_ids.size() - 1)];
        return make_req(act, sid, lt, amt, priv);
    endfunction

    task automatic run_random(input int n);
        repeat (n) push_req(gen_item(), 1'b0, '0);
    endtask

    // drop valid, let every result drain, then allow the pipeline to go quiet
    task automatic quiesce();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input int val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pscll_pkg::REG_RATE:  cfg_rate = val[pscll_pkg::RATE_W-1:0];
            pscll_pkg::REG_LIMIT: cfg_limit = val[pscll_pkg::LIMIT_W-1:0];
            pscll_pkg::REG_WARN:  cfg_warn = val[pscll_pkg::DEBIT_W-1:0];
            default:              cfg_cutoff = val[pscll_pkg::DEBIT_W-1:0];
        endcase
    endtask

    // result checker
    always @(posedge i_clk) begin
        pscll_pkg::t_rsp got, want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got = rsp_if.data;
            results_seen++;
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: %p", got));
            end else begin
                want = verdict_q.pop_front();
                if (got.needs_action !== want.needs_action)
                    report_mismatch($sformatf("needs_action got %b want %b",
                                              got.needs_action, want.needs_action));
                if (got.first_report !== want.first_report)
                    report_mismatch($sformatf("first_report got %b want %b",
                                              got.first_report, want.first_report));
                if (got.balance_now !== want.balance_now)
                    report_mismatch($sformatf("balance_now got %0d want %0d",
                                              got.balance_now, want.balance_now));
            end
        end
    end

    // result sink: random stalls plus one long hold-off to back up the block
    initial begin
        int  gap;
        bit  held;
        held = 1'b0;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held && results_seen >= 60) begin
                held = 1'b1;
                @(negedge i_clk);
                rsp_if.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                @(negedge i_clk);
                rsp_if.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            rsp_if.ready <= 1'b1;
        end
    end

    initial begin
        #3_000_000;
        $display("FAIL per_source_credit_load_limiter_top");
        $finish;
    end

    initial begin
        pscll_pkg::t_req r;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        // act, sid, lt, amt, priv, typed, needs, first, balance
        add_row(pscll_pkg::ACT_INIT,   0,  0,      0, 0, 1, 0, 0,      0);
        add_row(pscll_pkg::ACT_INIT,   63, 0,      0, 0, 1, 0, 0,      0);
        add_row(pscll_pkg::ACT_CHARGE, 0,  2,      0, 0, 1, 0, 0,   -100);
        add_row(pscll_pkg::ACT_ADJUST, 63, 0, -32768, 0, 1, 1, 0, -32768);
        add_row(pscll_pkg::ACT_ADJUST, 63, 0,  32767, 0, 1, 0, 0,     -1);
        add_row(pscll_pkg::ACT_ADJUST, 0,  0,  32767, 0, 1, 0, 0,    500);
        add_row(pscll_pkg::ACT_CHARGE, 0,  15,     0, 1, 1, 0, 0,    500);
        add_row(pscll_pkg::ACT_ADJUST, 63, 0,  -1000, 1, 1, 0, 0,  -1001);
        add_row(pscll_pkg::ACT_WARN,   63, 0,      0, 0, 0, 0, 0,      0);
        add_row(pscll_pkg::ACT_CUTOFF, 63, 0,      0, 0, 1, 1, 1,  -1001);
        add_row(pscll_pkg::ACT_CUTOFF, 63, 0,      0, 0, 1, 1, 0,  -1001);
        add_row(pscll_pkg::ACT_CUTOFF, 63, 0,      0, 1, 1, 0, 0,  -1001);
        add_row(pscll_pkg::ACT_TICK,   0,  0,      0, 0, 1, 0, 0,      0);
        add_row(pscll_pkg::ACT_WARN,   63, 0,      0, 0, 0, 0, 0,      0);
        add_row(pscll_pkg::ACT_WARN,   63, 0,      0, 0, 0, 0, 0,      0);
        add_row(pscll_pkg::ACT_CHARGE, 63, 8,      0, 0, 0, 0, 0,      0);
        add_row(3'd6,                  5,  0,      0, 0, 1, 0, 0,      0);
        add_row(3'd7,                  63, 15,    -1, 1, 1, 0, 0,      0);
        add_row(pscll_pkg::ACT_TICK,   0,  0,      0, 0, 1, 0, 0,      0);
        add_row(pscll_pkg::ACT_TICK,   0,  0,      0, 0, 1, 0, 0,      0);
        add_row(pscll_pkg::ACT_ADJUST, 63, 0,      0, 0, 0, 0, 0,      0);
        add_row(pscll_pkg::ACT_ADJUST, 63, 0,  32767, 0, 0, 0, 0,      0);
        add_row(pscll_pkg::ACT_TICK,   0,  0,      0, 0, 1, 0, 0,      0);
        add_row(pscll_pkg::ACT_ADJUST, 63, 0, -32768, 0, 0, 0, 0,      0);
        add_row(pscll_pkg::ACT_CUTOFF, 63, 0,      0, 0, 0, 0, 0,      0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].req.action == pscll_pkg::ACT_INIT)
                mark_live(int'(dir_rows[k].req.source_id));
            push_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
        end
        run_random(100);
        quiesce();

        set_reg(pscll_pkg::REG_RATE, 0);
        set_reg(pscll_pkg::REG_LIMIT, 0);
        set_reg(pscll_pkg::REG_WARN, 0);
        set_reg(pscll_pkg::REG_CUTOFF, 0);
        run_random(90);
        quiesce();

        set_reg(pscll_pkg::REG_RATE, 1000);
        set_reg(pscll_pkg::REG_LIMIT, 1000000);
        set_reg(pscll_pkg::REG_WARN, -1000000);
        set_reg(pscll_pkg::REG_CUTOFF, -1000000);
        run_random(90);
        quiesce();

        // drive one source down to the negative rail and probe it there
        set_reg(pscll_pkg::REG_RATE, 1);
        set_reg(pscll_pkg::REG_LIMIT, 1000);
        set_reg(pscll_pkg::REG_WARN, -1000);
        set_reg(pscll_pkg::REG_CUTOFF, -2000);
        mark_live(42);
        push_req(make_req(pscll_pkg::ACT_INIT, 42, 0, 0, 0), 1'b0, '0);
        repeat (270) begin
            r = make_req(pscll_pkg::ACT_ADJUST, 42, $urandom_range(0, 15), -32768,
                         $urandom_range(0, 1));
            push_req(r, 1'b0, '0);
        end
        push_req(make_req(pscll_pkg::ACT_CUTOFF, 42, 0, 0, 0), 1'b0, '0);
        push_req(make_req(pscll_pkg::ACT_WARN, 42, 0, 0, 0), 1'b0, '0);
        push_req(make_req(pscll_pkg::ACT_CHARGE, 42, 2, 0, 0), 1'b0, '0);
        push_req(make_req(pscll_pkg::ACT_ADJUST, 42, 0, 32767, 0), 1'b0, '0);
        run_random(60);
        quiesce();

        set_reg(pscll_pkg::REG_RATE, $urandom_range(0, 1000));
        set_reg(pscll_pkg::REG_LIMIT, $urandom_range(0, 5000));
        set_reg(pscll_pkg::REG_WARN, -int'($urandom_range(0, 3000)));
        set_reg(pscll_pkg::REG_CUTOFF, -int'($urandom_range(0, 6000)));
        idle_on = 1'b0;
        run_random(80);
        idle_on = 1'b1;
        run_random(80);
        quiesce();

        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS per_source_credit_load_limiter_top");
        end else begin
            $display("FAIL per_source_credit_load_limiter_top");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/pscll_pkg.sv
hdl/pscll_if.sv
hdl/per_source_credit_load_limiter_top.sv
hdl/pscll_chk.sv
tb/tb_per_source_credit_load_limiter_top.sv
